@@ sv/rskc_pkg.sv @@
`default_nettype none
package rskc_pkg;

    localparam int LOOKAHEAD_DEPTH_DEF = 20;
    localparam int SAMPLE_BITS_DEF     = 24;

    localparam logic signed [15:0] DB_FLOOR    = -16'sd30720;
    localparam logic [17:0]        DB_PER_LOG2 = 18'd197283;
    localparam logic [13:0]        LOG2_PER_DB = 14'd10885;
    localparam logic [16:0]        UNITY       = 17'd65536;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SLOPE     = 3'd1;
    localparam logic [2:0] REG_KNEE      = 3'd2;
    localparam logic [2:0] REG_ATTACK    = 3'd3;
    localparam logic [2:0] REG_RELEASE   = 3'd4;
    localparam logic [2:0] REG_AVERAGE   = 3'd5;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
    localparam logic [15:0]        SLOPE_RST     = 16'd49152;
    localparam logic [13:0]        KNEE_RST      = 14'd0;
    localparam logic [15:0]        ATTACK_RST    = 16'd6554;
    localparam logic [15:0]        RELEASE_RST   = 16'd655;
    localparam logic [15:0]        AVERAGE_RST   = 16'd655;

    function automatic logic [16:0] log2_lut(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0: v = 17'd0;      5'd1: v = 17'd5732;   5'd2: v = 17'd11136;
            5'd3: v = 17'd16248;  5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
            5'd6: v = 17'd30109;  5'd7: v = 17'd34312;  5'd8: v = 17'd38336;
            5'd9: v = 17'd42196;  5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
            5'd12: v = 17'd52911; 5'd13: v = 17'd56229; 5'd14: v = 17'd59434;
            5'd15: v = 17'd62534; default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp2_lut(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
            5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
            5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
            5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
            5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
            5'd15: v = 17'd34219; default: v = 17'd32768;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [15:0] threshold;
        logic [15:0]        slope;
        logic [13:0]        knee;
        logic [15:0]        attack;
        logic [15:0]        release_c;
        logic [15:0]        average;
    } cfg_t;

endpackage
`default_nettype wire

@@ sv/rskc_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module rskc_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [34:0] divisor,
    output logic             busy,
    output logic [47:0]      quotient
);
    logic [5:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [47:0] q_reg;
    logic [34:0] den_reg;
    logic [35:0] trial;

    assign trial = {rem_reg, q_reg[47]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd48;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            den_reg <= divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!trial[35])
            begin
                rem_reg <= trial[34:0];
                q_reg   <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[33:0], q_reg[47]};
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;

    property p_cnt_dec;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg != 6'd0 && !start) |=> (cnt_reg == $past(cnt_reg) - 6'd1);
    endproperty
    a_cnt_dec: assert property (p_cnt_dec) else $error("divider count slip");

    property p_start_load;
        @(posedge clk) disable iff (!rst_n) start |=> cnt_reg == 6'd48;
    endproperty
    a_start_load: assert property (p_start_load) else $error("divider not loaded");

    property p_busy;
        @(posedge clk) disable iff (!rst_n) $fell(busy) |-> cnt_reg == 6'd0;
    endproperty
    a_busy: assert property (p_busy) else $error("divider busy mismatch");
endmodule
`default_nettype wire

@@ sv/rms_soft_knee_compressor.sv @@
`default_nettype none
// Feed-forward RMS compressor with soft knee and look-ahead delay.
// Input stream s_axis (tdata = sample_in, sign in top bit, zero padded to bytes).
// Output stream m_axis (tdata = sample_out in low bits, applied_gain above).
// Configuration: cfg_we/cfg_addr/cfg_wdata, written one register per edge;
// write only while the block is idle, which the block itself does not enforce.
// One sample at a time: s_axis_tready is high only in the idle state.
// An item passes a sequence of steps on one shared multiplier:
// square, mean square update, log table interpolation, dB scaling, knee
// slope, exponent, exp table, smoothing and the final gain multiply. The
// soft knee adds a slope multiply and a 48-step bit-serial divide.
// The dB scaling step is skipped when the mean square is zero, and samples
// do not overlap: a new one is taken only once the previous one has passed
// every step and left the sequencer.
// The result moves to an output register, so the next sample is taken while
// it waits; a second finished result holds in the sequencer and keeps
// s_axis_tready low until the receiver takes the first. Reset restores the
// register defaults, unity gain, zero mean square and a zero look-ahead line;
// the line reads zero until written through a per-entry valid flag.
module rms_soft_knee_compressor
#(
    parameter int LOOKAHEAD_DEPTH = rskc_pkg::LOOKAHEAD_DEPTH_DEF,
    parameter int SAMPLE_BITS     = rskc_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_in
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [((SAMPLE_BITS+17+7)/8)*8-1:0] m_axis_tdata, // sample_out, applied_gain
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_addr,
    input  wire logic [15:0]                   cfg_wdata
);
    localparam int PW = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
    localparam int SB = SAMPLE_BITS;
    localparam int OW = ((SB + 17 + 7) / 8) * 8;
    localparam int SH = 2 * (SB - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_MS1, S_MS2, S_LOG, S_DB, S_KNEE, S_KSL, S_DIVW, S_EXP,
        S_EXPT, S_SM1, S_SM2, S_OUTM, S_OUT
    } state_t;

    state_t state_reg;
    rskc_pkg::cfg_t cfg_reg;
    logic [31:0] ms_reg;
    logic [16:0] gain_reg;
    logic [SB-1:0] line_mem [LOOKAHEAD_DEPTH];
    logic [LOOKAHEAD_DEPTH-1:0] line_vld_reg;
    logic [PW-1:0] ptr_reg;
    logic signed [SB-1:0] x_reg, dly_reg;
    logic [63:0] acc_reg;      // multiplier result / scratch
    logic [31:0] sq_reg;
    logic signed [15:0] lvl_reg;
    logic [47:0] red_reg;      // reduction magnitude
    logic [16:0] g_reg;        // new linear gain
    logic [SB-1:0] y_reg;
    logic [OW-1:0] out_reg;

    // shared multiplier
    logic [35:0] ma, mb;
    logic [71:0] mp;
    assign mp = ma * mb;

    // divider for soft knee
    logic        div_start, div_busy;
    logic [47:0] div_q;
    logic [47:0] div_n;
    logic [34:0] div_d;
    rskc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
        .divisor(div_d), .busy(div_busy), .quotient(div_q)
    );

    // --- combinational helpers
    logic signed [SB-1:0] x_in;
    logic [SB-1:0] xmag;
    logic [31:0] sq_sat;
    logic [4:0] lz_p;
    logic [31:0] mnorm;
    logic [16:0] lfrac;
    logic [63:0] dbm;
    logic signed [17:0] d_diff;
    logic signed [18:0] d2;
    logic signed [18:0] wsig;
    logic in_knee;
    logic [19:0] v_knee;
    logic [31:0] e_int;
    logic [4:0] e_idx;
    logic [11:0] e_rem;
    logic [15:0] coef;
    logic [PW-1:0] ptr_nxt;
    logic [71:0] y_full;

    function automatic logic [16:0] UNITY17(input logic [15:0] c);
        return rskc_pkg::UNITY - {1'b0, c};
    endfunction

    assign x_in = s_axis_tdata[SB-1:0];
    assign xmag = x_reg[SB-1] ? SB'(-x_reg) : SB'(x_reg);

    always_comb
    begin
        lz_p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (ms_reg[i])
            begin
                lz_p = 5'(i);
            end
        end
        mnorm = ms_reg << (5'd31 - lz_p);
    end

    assign lfrac   = rskc_pkg::log2_lut({1'b0, mnorm[30:27]}) + 17'(mp >> 16);
    assign dbm     = 64'(mp) + 64'h80_0000;
    assign d_diff  = 18'(lvl_reg) - 18'(cfg_reg.threshold);
    assign d2      = 19'(d_diff) <<< 1;
    assign wsig    = 19'({5'd0, cfg_reg.knee});
    assign in_knee = (cfg_reg.knee != 14'd0) && (d2 > -wsig) && (d2 < wsig);
    assign v_knee  = 20'(d2 + wsig);
    assign e_int   = acc_reg[55:24];
    assign e_idx   = {1'b0, acc_reg[23:20]};
    assign e_rem   = acc_reg[19:8];
    assign coef    = (g_reg < gain_reg) ? cfg_reg.attack : cfg_reg.release_c;
    assign ptr_nxt = (32'(ptr_reg) + 32'd1 >= 32'(LOOKAHEAD_DEPTH)) ? '0 : ptr_reg + PW'(1);
    // sign-extended operand is 36 bits wide; remove the excess above bit 35
    assign y_full  = mp - (dly_reg[SB-1] ? {19'd0, gain_reg, 36'd0} : 72'd0);

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_SQ:   begin ma = 36'(xmag); mb = 36'(xmag); end
            S_MS1:  begin ma = 36'(UNITY17(cfg_reg.average)); mb = 36'(ms_reg); end
            S_MS2:  begin ma = 36'(cfg_reg.average); mb = 36'(sq_reg); end
            S_LOG:  begin
                        ma = 36'(rskc_pkg::log2_lut({1'b0, mnorm[30:27]} + 5'd1)
                             - rskc_pkg::log2_lut({1'b0, mnorm[30:27]}));
                        mb = 36'(mnorm[26:11]);
                    end
            S_DB:   begin ma = 36'(acc_reg[35:0]); mb = 36'(rskc_pkg::DB_PER_LOG2); end
            S_KNEE: begin
                        if (in_knee) begin ma = 36'(v_knee); mb = 36'(v_knee); end
                        else begin ma = 36'(d_diff[16:0]); mb = 36'(cfg_reg.slope); end
                    end
            S_KSL:  begin ma = 36'(acc_reg[35:0]); mb = 36'(cfg_reg.slope); end
            S_EXP:  begin ma = 36'(red_reg[31:0]); mb = 36'(rskc_pkg::LOG2_PER_DB); end
            S_EXPT: begin
                        ma = 36'(rskc_pkg::exp2_lut(e_idx) - rskc_pkg::exp2_lut(e_idx + 5'd1));
                        mb = 36'(e_rem);
                    end
            S_SM1:  begin ma = 36'(UNITY17(coef)); mb = 36'(gain_reg); end
            S_SM2:  begin ma = 36'(coef); mb = 36'(g_reg); end
            S_OUTM: begin
                        ma = 36'({{(36-SB){dly_reg[SB-1]}}, dly_reg});
                        mb = 36'(gain_reg);
                    end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign sq_sat = (acc_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : acc_reg[31:0];

    // full product shifted to Q0.32
    logic [63:0] sq_full;
    always_comb
    begin
        if (SH >= 32)
            sq_full = 64'(mp) >> (SH >= 32 ? SH - 32 : 0);
        else
            sq_full = 64'(mp) << (SH < 32 ? 32 - SH : 0);
    end

    // dividend slope*v*v, divisor 8*W in Q16
    assign div_start = (state_reg == S_KSL);
    assign div_n     = mp[47:0];
    assign div_d     = 35'({cfg_reg.knee, 19'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg.threshold <= rskc_pkg::THRESHOLD_RST;
            cfg_reg.slope     <= rskc_pkg::SLOPE_RST;
            cfg_reg.knee      <= rskc_pkg::KNEE_RST;
            cfg_reg.attack    <= rskc_pkg::ATTACK_RST;
            cfg_reg.release_c <= rskc_pkg::RELEASE_RST;
            cfg_reg.average   <= rskc_pkg::AVERAGE_RST;
            ms_reg        <= '0;
            gain_reg      <= rskc_pkg::UNITY;
            line_vld_reg  <= '0;
            ptr_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    rskc_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata;
                    rskc_pkg::REG_SLOPE:     cfg_reg.slope     <= cfg_wdata;
                    rskc_pkg::REG_KNEE:      cfg_reg.knee      <= cfg_wdata[13:0];
                    rskc_pkg::REG_ATTACK:    cfg_reg.attack    <= cfg_wdata;
                    rskc_pkg::REG_RELEASE:   cfg_reg.release_c <= cfg_wdata;
                    rskc_pkg::REG_AVERAGE:   cfg_reg.average   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        line_vld_reg[ptr_reg] <= 1'b1;
                        ptr_reg   <= ptr_nxt;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:  state_reg <= S_MS1;
                S_MS1: state_reg <= S_MS2;
                S_MS2:
                begin
                    ms_reg    <= (65'(acc_reg) + 65'(mp)) >> 16 > 65'h0_FFFF_FFFF
                                 ? 32'hFFFF_FFFF : 32'((65'(acc_reg) + 65'(mp)) >> 16);
                    state_reg <= S_LOG;
                end
                S_LOG: state_reg <= (ms_reg == 32'd0) ? S_KNEE : S_DB;
                S_DB:  state_reg <= S_KNEE;
                S_KNEE: state_reg <= in_knee ? S_KSL : S_EXP;
                S_KSL:  state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (!div_busy)
                        state_reg <= S_EXP;
                end
                S_EXP:  state_reg <= S_EXPT;
                S_EXPT: state_reg <= S_SM1;
                S_SM1:  state_reg <= S_SM2;
                S_SM2:
                begin
                    gain_reg  <= 17'((acc_reg + 64'(mp) + 64'd32768) >> 16);
                    state_reg <= S_OUTM;
                end
                S_OUTM: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!m_axis_tvalid || m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath (no reset)
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    x_reg   <= x_in;
                    dly_reg <= line_vld_reg[ptr_reg] ? line_mem[ptr_reg] : '0;
                    line_mem[ptr_reg] <= x_in;
                end
            end
            S_SQ:  acc_reg <= sq_full;
            S_MS1:
            begin
                sq_reg  <= sq_sat;
                acc_reg <= 64'(mp);
            end
            S_MS2: ;
            S_LOG:
            begin
                acc_reg <= 64'((6'd32 - {1'b0, lz_p}) * 23'd65536) - 64'(lfrac);
                lvl_reg <= rskc_pkg::DB_FLOOR;
            end
            S_DB:
            begin
                if ((dbm >> 24) > 64'd30720)
                    lvl_reg <= rskc_pkg::DB_FLOOR;
                else
                    lvl_reg <= -16'(dbm >> 24);
            end
            S_KNEE:
            begin
                acc_reg <= 64'(mp);
                if (!in_knee && d_diff > 18'sd0)
                    red_reg <= 48'(mp >> 16);
                else
                    red_reg <= '0;
            end
            S_KSL: ;
            S_DIVW:
            begin
                if (!div_busy)
                    red_reg <= div_q;
            end
            S_EXP:  acc_reg <= 64'(mp);
            S_EXPT:
            begin
                if (e_int >= 32'd17)
                    g_reg <= '0;
                else
                    g_reg <= 17'((rskc_pkg::exp2_lut(e_idx) - 17'(mp >> 12)) >> e_int[4:0]);
            end
            S_SM1:  acc_reg <= 64'(mp);
            S_SM2:  ;
            S_OUTM:
            begin
                y_reg <= SB'(y_full >> 16);
            end
            S_OUT:
            begin
                if (!m_axis_tvalid || m_axis_tready)
                    out_reg <= OW'({gain_reg, y_reg});
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tdata  = out_reg;

    property p_one_side;
        @(posedge clk) disable iff (!rst_n) s_axis_tready |-> state_reg == S_IDLE;
    endproperty
    a_one_side: assert property (p_one_side) else $error("ready outside idle");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_gain_max;
        @(posedge clk) disable iff (!rst_n) gain_reg <= rskc_pkg::UNITY;
    endproperty
    a_gain_max: assert property (p_gain_max) else $error("gain above unity");
endmodule
`default_nettype wire
